// File: src/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared widths, register and blend mode codes and the opacity and mix curve
// tables of the layer blend pipeline.
// ----------------------------------------------------------------------------
package lbp_pkg;

    // Pixel and channel geometry
    localparam int CH_W       = 8;
    localparam int CH_N       = 4;
    localparam int COLOUR_N   = 3;
    localparam int PIX_W      = CH_W * CH_N;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int MODE_W     = 3;

    // Curve tables: one entry per percent, unsigned Q1.16 with 1.0 = 65536
    localparam int CURVE_N    = 101;
    localparam int Q16_W      = 17;

    localparam logic [CFG_DATA_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [CFG_DATA_W-1:0] PCT_RESET = 7'd50;
    localparam logic [Q16_W-1:0]      ONE_Q16   = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLEND_MODE = 2'd0,
        REG_OPACITY    = 2'd1,
        REG_MIX        = 2'd2
    } t_cfg_reg;

    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL     = 3'd0,
        MODE_MULTIPLY   = 3'd1,
        MODE_SCREEN     = 3'd2,
        MODE_OVERLAY    = 3'd3,
        MODE_DIFFERENCE = 3'd4
    } t_blend_mode;

    typedef logic [CURVE_N-1:0][Q16_W-1:0] t_curve_rom;

    // Largest y with y - 1/2 <= 65536 * f(pct), found by exact integer
    // bisection; f is (pct/100)^0.8 or sqrt(pct/100). Elaboration only.
    function automatic logic [Q16_W-1:0] curve_entry(input logic [CFG_DATA_W-1:0] pct,
                                                     input logic is_pow);
        logic [17:0]  lo;
        logic [17:0]  hi;
        logic [17:0]  mid;
        logic [127:0] d;
        logic [127:0] p;
        logic [127:0] lhs;
        logic [127:0] rhs;
        int           i;
        lo = 18'd0;
        hi = 18'(ONE_Q16);
        p  = 128'(pct);
        for (i = 0; i < 20; i++) begin
            if (lo < hi) begin
                mid = (lo + hi + 18'd1) >> 1;
                d   = 128'(mid) * 128'd2 - 128'd1;
                if (is_pow) begin
                    // (2y-1)^5 * 10^8 <= p^4 * 2^85
                    lhs = d * d * d * d * d * 128'd100000000;
                    rhs = (p * p * p * p) << 85;
                end else begin
                    // (2y-1)^2 * 100 <= p * 2^34
                    lhs = d * d * 128'd100;
                    rhs = p << 34;
                end
                if (lhs <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid - 18'd1;
                end
            end
        end
        return lo[Q16_W-1:0];
    endfunction

    function automatic t_curve_rom build_curve(input logic is_pow);
        t_curve_rom rom;
        int         k;
        for (k = 0; k < CURVE_N; k++) begin
            rom[k] = curve_entry(CFG_DATA_W'(k), is_pow);
        end
        return rom;
    endfunction

    localparam t_curve_rom OPA_ROM = build_curve(1'b1);
    localparam t_curve_rom MIX_ROM = build_curve(1'b0);

endpackage

// File: src/lbp_if.sv
// ----------------------------------------------------------------------------
// lbp interfaces
// Valid/ready channels of the layer blend pipeline: pixel pair in, blended
// pixel out, and the configuration write channel.
// ----------------------------------------------------------------------------
interface lbp_pix_in_if;
    import lbp_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] base_pixel;
    logic [PIX_W-1:0] top_pixel;

    modport source (output valid, output base_pixel, output top_pixel, input ready);
    modport sink   (input valid, input base_pixel, input top_pixel, output ready);
endinterface

interface lbp_pix_out_if;
    import lbp_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] result_pixel;

    modport source (output valid, output result_pixel, input ready);
    modport sink   (input valid, input result_pixel, output ready);
endinterface

interface lbp_cfg_if;
    import lbp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/layer_blend_pixel.sv
// Throughput: one pixel pair per cycle while the output is not stalled; each of
// the five stages hands on its transaction as soon as the next stage has room,
// so a stall only backs up. Reset (synchronous, active low) empties the pipeline
// and loads the register defaults: normal mode, opacity 50 %, mix 50 %.
// ----------------------------------------------------------------------------
// layer_blend_pixel
// Five stage blend of a top BGRA pixel over a base pixel: blend mode, opacity
// scaled alpha composite, reciprocal division to 8 bits, then mix toward base.
// ----------------------------------------------------------------------------
module layer_blend_pixel (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lbp_cfg_if.sink       i_cfg,
    lbp_pix_in_if.sink    i_pix,
    lbp_pix_out_if.source o_pix
);
    import lbp_pkg::*;

    localparam logic [CH_W-1:0]  CH_MAX     = 8'd255;
    localparam logic [CH_W-1:0]  OVL_SPLIT  = 8'd128;
    localparam logic [15:0]      SQ_MAX     = 16'd65025;
    localparam logic [23:0]      DEN        = 24'd16711680;      // 255 * 65536
    localparam logic [40:0]      RND_C      = 41'd2130739200;    // 65025 * 32768
    localparam logic [32:0]      RND_A      = 33'd8355840;       // 255 * 32768
    localparam logic [24:0]      DIV_C      = 25'd65025;
    localparam logic [16:0]      DIV_A      = 17'd255;
    localparam int               RCP_C_SH   = 40;
    localparam int               RCP_A_SH   = 24;
    localparam logic [24:0]      RCP_C      = 25'((64'd1 << RCP_C_SH) / 64'd65025);
    localparam logic [16:0]      RCP_A      = 17'((64'd1 << RCP_A_SH) / 64'd255);
    localparam logic [24:0]      HALF_Q16   = 25'd32768;

    // Blend value of one colour channel as a numerator over 255*255
    function automatic logic [15:0] mode_value(input t_blend_mode mode,
                                               input logic [CH_W-1:0] b,
                                               input logic [CH_W-1:0] t);
        logic [CH_W-1:0] nb;
        logic [CH_W-1:0] nt;
        logic [CH_W-1:0] diff;
        logic [15:0]     prod;
        logic [15:0]     nprod;
        logic [15:0]     mv;
        nb    = CH_MAX - b;
        nt    = CH_MAX - t;
        diff  = (b > t) ? (b - t) : (t - b);
        prod  = 16'(b) * 16'(t);
        nprod = 16'(nb) * 16'(nt);
        case (mode)
            MODE_MULTIPLY:   mv = prod;
            MODE_SCREEN:     mv = SQ_MAX - nprod;
            MODE_OVERLAY: begin
                if (b < OVL_SPLIT) begin
                    mv = prod << 1;
                end else begin
                    mv = SQ_MAX - (nprod << 1);
                end
            end
            MODE_DIFFERENCE: mv = 16'(diff) * 16'(CH_MAX);
            default:         mv = 16'(t) * 16'(CH_MAX);
        endcase
        return mv;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers, stored as curve values
    // ------------------------------------------------------------------
    t_blend_mode           r_mode;
    logic [Q16_W-1:0]      r_opa_f;
    logic [Q16_W-1:0]      r_mix_m;
    logic                  r_mix_byp;
    logic [CFG_DATA_W-1:0] n_cfg_pct;

    assign i_cfg.ready = 1'b1;

    // Saturate percentages at 100
    always_comb begin
        n_cfg_pct = (i_cfg.data > PCT_FULL) ? PCT_FULL : i_cfg.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NORMAL;
            r_opa_f   <= OPA_ROM[PCT_RESET];
            r_mix_m   <= MIX_ROM[PCT_RESET];
            r_mix_byp <= 1'b0;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_BLEND_MODE: r_mode  <= t_blend_mode'(i_cfg.data[MODE_W-1:0]);
                REG_OPACITY:    r_opa_f <= OPA_ROM[n_cfg_pct];
                REG_MIX: begin
                    r_mix_m   <= MIX_ROM[n_cfg_pct];
                    r_mix_byp <= (n_cfg_pct == PCT_FULL);
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: a stage advances when empty or when its successor does
    // ------------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r_s5_v || o_pix.ready;
    assign en4 = !r_s4_v || en5;
    assign en3 = !r_s3_v || en4;
    assign en2 = !r_s2_v || en3;
    assign en1 = !r_s1_v || en2;

    assign i_pix.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else begin
            if (en1) r_s1_v <= i_pix.valid;
            if (en2) r_s2_v <= r_s1_v;
            if (en3) r_s3_v <= r_s2_v;
            if (en4) r_s4_v <= r_s3_v;
            if (en5) r_s5_v <= r_s4_v;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: adjusted top alpha and per-channel blend values
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_s1_base;
    logic [23:0]      r_s1_an;
    logic [15:0]      r_s1_bv [COLOUR_N];
    logic [23:0]      n_s1_an;
    logic [15:0]      n_s1_bv [COLOUR_N];

    always_comb begin
        n_s1_an = 24'(25'(i_pix.top_pixel[PIX_W-1 -: CH_W]) * 25'(r_opa_f));
        for (int c = 0; c < COLOUR_N; c++) begin
            n_s1_bv[c] = mode_value(r_mode, i_pix.base_pixel[c*CH_W +: CH_W],
                                    i_pix.top_pixel[c*CH_W +: CH_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_base <= i_pix.base_pixel;
            r_s1_an   <= n_s1_an;
            r_s1_bv   <= n_s1_bv;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: composite numerators, rounded and scaled down by 2^16
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_s2_base;
    logic [23:0]      r_s2_xc [COLOUR_N];
    logic [15:0]      r_s2_xa;
    logic [23:0]      n_s2_xc [COLOUR_N];
    logic [15:0]      n_s2_xa;
    logic [23:0]      n_s2_inv;
    logic [40:0]      n_s2_numc;
    logic [15:0]      n_s2_bb;
    logic [32:0]      n_s2_numa;

    always_comb begin
        n_s2_inv  = DEN - r_s1_an;
        n_s2_numc = '0;
        n_s2_bb   = '0;
        for (int c = 0; c < COLOUR_N; c++) begin
            n_s2_bb    = 16'(r_s1_base[c*CH_W +: CH_W]) * 16'(CH_MAX);
            n_s2_numc  = 41'(n_s2_bb) * 41'(n_s2_inv) + 41'(r_s1_bv[c]) * 41'(r_s1_an)
                         + RND_C;
            n_s2_xc[c] = n_s2_numc[39:16];
        end
        n_s2_numa = 33'(r_s1_base[PIX_W-1 -: CH_W]) * 33'(n_s2_inv)
                    + 33'(CH_MAX) * 33'(r_s1_an) + RND_A;
        n_s2_xa   = n_s2_numa[31:16];
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_base <= r_s1_base;
            r_s2_xc   <= n_s2_xc;
            r_s2_xa   <= n_s2_xa;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: quotient estimate by reciprocal multiply (low by at most one)
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_s3_base;
    logic [23:0]      r_s3_xc [COLOUR_N];
    logic [15:0]      r_s3_xa;
    logic [8:0]       r_s3_qc [COLOUR_N];
    logic [8:0]       r_s3_qa;
    logic [8:0]       n_s3_qc [COLOUR_N];
    logic [8:0]       n_s3_qa;
    logic [48:0]      n_s3_pc;
    logic [32:0]      n_s3_pa;

    always_comb begin
        n_s3_pc = '0;
        for (int c = 0; c < COLOUR_N; c++) begin
            n_s3_pc    = 49'(r_s2_xc[c]) * 49'(RCP_C);
            n_s3_qc[c] = n_s3_pc[48:RCP_C_SH];
        end
        n_s3_pa = 33'(r_s2_xa) * 33'(RCP_A);
        n_s3_qa = n_s3_pa[32:RCP_A_SH];
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_base <= r_s2_base;
            r_s3_xc   <= r_s2_xc;
            r_s3_xa   <= r_s2_xa;
            r_s3_qc   <= n_s3_qc;
            r_s3_qa   <= n_s3_qa;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: correct the quotient by one compare, clamp to 8 bits
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_s4_base;
    logic [CH_W-1:0]  r_s4_res [CH_N];
    logic [CH_W-1:0]  n_s4_res [CH_N];
    logic [24:0]      n_s4_remc;
    logic [16:0]      n_s4_rema;
    logic [9:0]       n_s4_q;

    always_comb begin
        n_s4_remc = '0;
        n_s4_q    = '0;
        for (int c = 0; c < COLOUR_N; c++) begin
            n_s4_remc   = 25'(r_s3_xc[c]) - 25'(25'(r_s3_qc[c]) * DIV_C);
            n_s4_q      = 10'(r_s3_qc[c]) + 10'(n_s4_remc >= DIV_C);
            n_s4_res[c] = (n_s4_q > 10'(CH_MAX)) ? CH_MAX : n_s4_q[CH_W-1:0];
        end
        n_s4_rema = 17'(r_s3_xa) - 17'(17'(r_s3_qa) * DIV_A);
        n_s4_q    = 10'(r_s3_qa) + 10'(n_s4_rema >= DIV_A);
        n_s4_res[CH_N-1] = (n_s4_q > 10'(CH_MAX)) ? CH_MAX : n_s4_q[CH_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_base <= r_s3_base;
            r_s4_res  <= n_s4_res;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: mix toward base, select bypasses, drive the output register
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_s5_pix;
    logic [PIX_W-1:0] n_s5_pix;
    logic [Q16_W-1:0] n_s5_invm;
    logic [24:0]      n_s5_num;
    logic [CH_W-1:0]  n_s5_ch;

    always_comb begin
        n_s5_invm = ONE_Q16 - r_mix_m;
        n_s5_num  = '0;
        n_s5_ch   = '0;
        n_s5_pix  = '0;
        for (int c = 0; c < CH_N; c++) begin
            n_s5_num = 25'(r_s4_base[c*CH_W +: CH_W]) * 25'(n_s5_invm)
                       + 25'(r_s4_res[c]) * 25'(r_mix_m) + HALF_Q16;
            n_s5_ch  = (n_s5_num[24:16] > 9'(CH_MAX)) ? CH_MAX : n_s5_num[23:16];
            if (r_mix_byp) begin
                n_s5_ch = r_s4_res[c];
            end
            n_s5_pix[c*CH_W +: CH_W] = n_s5_ch;
        end
        // Undefined modes leave the base pixel untouched
        if (r_mode > MODE_DIFFERENCE) begin
            n_s5_pix = r_s4_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_s5_pix <= n_s5_pix;
        end
    end

    assign o_pix.valid        = r_s5_v;
    assign o_pix.result_pixel = r_s5_pix;

endmodule

// File: src/lbp_checker.sv
// ----------------------------------------------------------------------------
// lbp_checker
// Port-level checks of the layer blend pipeline: transaction occupancy and
// output hold under stall.
// ----------------------------------------------------------------------------
module lbp_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [lbp_pkg::PIX_W-1:0] i_out_data
);
    import lbp_pkg::*;

    localparam logic [2:0] PIPE_DEPTH = 3'd5;

    logic [2:0] r_cnt;

    // Track transactions in flight between the two ports
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case ({i_in_valid && i_in_ready, i_out_valid && i_out_ready})
                2'b10:   r_cnt <= r_cnt + 3'd1;
                2'b01:   r_cnt <= r_cnt - 3'd1;
                default: ;
            endcase
        end
    end

    a_no_orphan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_cnt != 3'd0))
        else $error("result presented with no transaction in flight");

    a_bounded_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= PIPE_DEPTH)
        else $error("more transactions in flight than pipeline stages");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd0) |-> i_in_ready)
        else $error("input refused while pipeline empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result dropped or changed");

endmodule

bind layer_blend_pixel lbp_checker u_lbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_data  (o_pix.result_pixel)
);
